// ===== design/bsdr_pkg.sv =====
package bsdr_pkg;
   localparam int LATTICE_COLS_DEF = 64;
   localparam int LATTICE_ROWS_DEF = 64;
   localparam int SLOPE_W = 5;
   localparam int CRIT_SLOPE = 4;
   localparam int ROUNDS_W = 16;
   localparam int TOPPLE_W = 24;
   localparam int AREA_W = 13;
   localparam int COORD_W = 6;
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CONSERVATIVE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_AREA = 1'd1;

   typedef enum logic [2:0] {
      OP_NONE, OP_INIT, OP_DRIVE, OP_CLEAR, OP_SCAN, OP_TOPPLE
   } op_type;

   typedef struct packed {
      op_type op;
      logic   start;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic any_crit;
   } sts_type;

   function automatic logic signed [SLOPE_W-1:0] sat_add(
      input logic signed [SLOPE_W-1:0] v, input logic signed [3:0] d);
      logic signed [SLOPE_W+1:0] s;
      s = (SLOPE_W+2)'(v) + (SLOPE_W+2)'(d);
      if (s > 15) return SLOPE_W'(15);
      if (s < -16) return SLOPE_W'(-16);
      return s[SLOPE_W-1:0];
   endfunction
endpackage

// ===== design/bsdr_if.sv =====
interface bsdr_req_if;
   import bsdr_pkg::*;
   logic valid;
   logic ready;
   logic [COORD_W-1:0] drive_col;
   logic [COORD_W-1:0] drive_row;
   modport source (output valid, drive_col, drive_row, input ready);
   modport sink (input valid, drive_col, drive_row, output ready);
endinterface

interface bsdr_rsp_if;
   import bsdr_pkg::*;
   logic valid;
   logic ready;
   logic [ROUNDS_W-1:0] avalanche_rounds;
   logic [TOPPLE_W-1:0] avalanche_topplings;
   logic [AREA_W-1:0] avalanche_area;
   modport source (output valid, avalanche_rounds, avalanche_topplings, avalanche_area,
                   input ready);
   modport sink (input valid, avalanche_rounds, avalanche_topplings, avalanche_area,
                 output ready);
endinterface

// ===== design/bsdr_ctrl.sv =====
module bsdr_ctrl
   import bsdr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_go,
   output logic    req_ready,
   output logic    rsp_load,
   input  logic    rsp_busy,
   output cmd_type cmd,
   input  sts_type sts
);
   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_DRIVE, S_CLEAR, S_SCAN, S_TOPPLE, S_DONE
   } state_type;
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      cmd.start = 1'b0;
      rsp_load = 1'b0;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_INIT: begin
            cmd.op = OP_INIT;
            if (sts.done) begin state_in = S_IDLE; cmd.start = 1'b1; end
         end
         S_IDLE: if (req_go) state_in = S_DRIVE;
         S_DRIVE: begin
            cmd.op = OP_DRIVE;
            if (sts.done) begin state_in = S_CLEAR; cmd.start = 1'b1; end
         end
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.done) begin state_in = S_SCAN; cmd.start = 1'b1; end
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (sts.done) begin
               cmd.start = 1'b1;
               state_in = sts.any_crit ? S_TOPPLE : S_DONE;
            end
         end
         S_TOPPLE: begin
            cmd.op = OP_TOPPLE;
            if (sts.done) begin state_in = S_SCAN; cmd.start = 1'b1; end
         end
         S_DONE: if (!rsp_busy) begin rsp_load = 1'b1; state_in = S_IDLE; end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else state_ff <= state_in;
   end
endmodule

// ===== design/bsdr_dp.sv =====
module bsdr_dp
   import bsdr_pkg::*;
#(
   parameter int LATTICE_COLS = LATTICE_COLS_DEF,
   parameter int LATTICE_ROWS = LATTICE_ROWS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_go,
   input  logic [COORD_W-1:0]  req_col,
   input  logic [COORD_W-1:0]  req_row,
   input  logic                conservative,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic [ROUNDS_W-1:0] rounds,
   output logic [TOPPLE_W-1:0] topples,
   output logic [AREA_W-1:0]   area
);
   localparam int SITES = LATTICE_COLS * LATTICE_ROWS;
   localparam int CW = $clog2(LATTICE_COLS);
   localparam int RW = $clog2(LATTICE_ROWS);
   localparam int AW = CW + RW;
   localparam int DEPTH = 1 << AW;
   localparam int LW = $clog2(SITES);
   localparam int NW = $clog2(SITES + 1);
   localparam logic [CW-1:0] COL_LAST = CW'(LATTICE_COLS - 1);
   localparam logic [RW-1:0] ROW_LAST = RW'(LATTICE_ROWS - 1);

   // site memories addressed by {row, col}; each read-modify-write is a read phase then a write phase
   logic signed [SLOPE_W-1:0] slope_mem [DEPTH];
   logic                      touch_mem [DEPTH];
   logic [AW-1:0]             list_mem  [SITES];

   logic [CW-1:0] pc_ff, nxc;       // walk position for init, clear and scan
   logic [RW-1:0] pr_ff, nxr;
   logic [CW-1:0] dc_ff;
   logic [RW-1:0] dr_ff;
   logic          don_ff;
   logic [NW-1:0] cnt_ff, cnt_in, lix_ff, lix_in;
   logic [2:0]    sub_ff, sub_in;   // step within one site
   logic          ph_ff, ph_in;     // 0 read, 1 write
   logic signed [SLOPE_W-1:0] rd_ff;
   logic          tch_ff;
   logic [AW-1:0] lrd_ff;           // listed site being toppled
   logic [ROUNDS_W-1:0] rnd_ff;
   logic [TOPPLE_W-1:0] top_ff;
   logic [AREA_W-1:0]   area_ff;
   logic [CW-1:0] sc, ac;
   logic [RW-1:0] sr, ar;
   logic [AW-1:0] addr;
   logic          act, wen, mk, last, crit, adv;
   logic signed [3:0] delta;

   // address and delta of current step
   always_comb begin
      sc = pc_ff; sr = pr_ff;
      if (cmd.op == OP_DRIVE) begin
         sc = dc_ff; sr = dr_ff;
      end else if (cmd.op == OP_TOPPLE) begin
         sc = lrd_ff[CW-1:0]; sr = lrd_ff[AW-1:CW];
      end
      ac = sc; ar = sr; act = 1'b0; delta = '0; mk = 1'b0;
      unique case (cmd.op)
         OP_DRIVE: begin
            unique case (sub_ff)
               3'd0: begin act = don_ff; delta = conservative ? 4'sd2 : 4'sd1; end
               3'd1: begin act = don_ff && conservative && sc != '0; ac = sc - 1'b1;
                  delta = -4'sd1; end
               3'd2: begin act = don_ff && conservative && sr != '0; ar = sr - 1'b1;
                  delta = -4'sd1; end
               default: act = 1'b0;
            endcase
         end
         OP_TOPPLE: begin
            mk = 1'b1;
            unique case (sub_ff)
               3'd1: begin act = 1'b1; delta = -4'sd4; end
               3'd2: begin act = sc != '0; ac = sc - 1'b1; delta = 4'sd1; end
               3'd3: begin act = sc != COL_LAST; ac = sc + 1'b1; delta = 4'sd1; end
               3'd4: begin act = sr != '0; ar = sr - 1'b1; delta = 4'sd1; end
               3'd5: begin act = sr != ROW_LAST; ar = sr + 1'b1; delta = 4'sd1; end
               default: act = 1'b0; // step 0 fetches the listed site
            endcase
         end
         default: ;
      endcase
      addr = {ar, ac};
      wen = act && ph_ff;
   end

   always_ff @(posedge clock) begin
      rd_ff <= slope_mem[addr];
      tch_ff <= touch_mem[addr];
      lrd_ff <= list_mem[lix_ff[LW-1:0]];
      if (cmd.op == OP_INIT) slope_mem[addr] <= '0;
      else if (wen) slope_mem[addr] <= sat_add(rd_ff, delta);
      if (cmd.op == OP_INIT || cmd.op == OP_CLEAR) touch_mem[addr] <= 1'b0;
      else if (wen && mk) touch_mem[addr] <= 1'b1;
      if (cmd.op == OP_SCAN && ph_ff && crit) list_mem[cnt_ff[LW-1:0]] <= addr;
   end

   // sequencing
   always_comb begin
      last = (pc_ff == COL_LAST) && (pr_ff == ROW_LAST);
      crit = (rd_ff >= CRIT_SLOPE);
      if (pc_ff == COL_LAST) begin
         nxc = '0; nxr = pr_ff + 1'b1;
      end else begin
         nxc = pc_ff + 1'b1; nxr = pr_ff;
      end
      lix_in = lix_ff; cnt_in = cnt_ff; sub_in = sub_ff; ph_in = ~ph_ff; adv = 1'b0;
      sts.done = 1'b0;
      unique case (cmd.op)
         OP_INIT, OP_CLEAR: begin
            ph_in = 1'b0;
            if (last) sts.done = 1'b1; else adv = 1'b1;
         end
         OP_DRIVE: if (ph_ff) begin
            if (sub_ff == 3'd2) sts.done = 1'b1; else sub_in = sub_ff + 1'b1;
         end
         OP_SCAN: if (ph_ff) begin
            if (crit) cnt_in = cnt_ff + 1'b1;
            if (last) sts.done = 1'b1; else adv = 1'b1;
         end
         OP_TOPPLE: if (ph_ff) begin
            if (sub_ff == 3'd5) begin
               sub_in = '0;
               if (lix_ff + 1'b1 == cnt_ff) sts.done = 1'b1;
               else lix_in = lix_ff + 1'b1;
            end else sub_in = sub_ff + 1'b1;
         end
         default: ph_in = 1'b0;
      endcase
      sts.any_crit = (cnt_in != '0);
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         dc_ff <= CW'(req_col); dr_ff <= RW'(req_row);
         don_ff <= (int'(req_col) < LATTICE_COLS) && (int'(req_row) < LATTICE_ROWS);
      end
      if (reset) begin
         pc_ff <= '0; pr_ff <= '0;
         lix_ff <= '0; cnt_ff <= '0; sub_ff <= '0; ph_ff <= 1'b0;
         rnd_ff <= '0; top_ff <= '0; area_ff <= '0;
      end else begin
         if (req_go) begin rnd_ff <= '0; top_ff <= '0; area_ff <= '0; end
         if (wen && mk && !tch_ff) area_ff <= area_ff + 1'b1;
         if (cmd.op == OP_SCAN && sts.done) begin
            if (sts.any_crit && rnd_ff != '1) rnd_ff <= rnd_ff + 1'b1;
            if (TOPPLE_W'(cnt_in) > ~top_ff) top_ff <= '1;
            else top_ff <= top_ff + TOPPLE_W'(cnt_in);
         end
         if (cmd.start || req_go) begin
            pc_ff <= '0; pr_ff <= '0; lix_ff <= '0; sub_ff <= '0; ph_ff <= 1'b0;
            if (cmd.op == OP_SCAN) cnt_ff <= cnt_in;
            else cnt_ff <= '0;
         end else begin
            if (adv) begin pc_ff <= nxc; pr_ff <= nxr; end
            lix_ff <= lix_in; cnt_ff <= cnt_in; sub_ff <= sub_in; ph_ff <= ph_in;
         end
      end
   end

   assign rounds = rnd_ff;
   assign topples = top_ff;
   assign area = area_ff;
endmodule

// ===== design/btw_sandpile_drive_relax.sv =====
// sequence: after acceptance, a drive step, a clear pass over all sites, then scan passes
// (rounds+1) alternating with topple passes, then the result register loads
// flow: one transaction at a time; the next request is not accepted until the result
// loads, which waits while the previous result is still unaccepted
// reset: synchronous active high; a clearing pass over all sites zeroes the
// lattice, input held not ready meanwhile
module btw_sandpile_drive_relax
   import bsdr_pkg::*;
#(
   parameter int LATTICE_COLS = LATTICE_COLS_DEF,
   parameter int LATTICE_ROWS = LATTICE_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bsdr_req_if.sink              req,
   bsdr_rsp_if.source            rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic                  csr_write_data
);
   logic cons_ff, area_en_ff, vld_ff, go, load;
   logic [ROUNDS_W-1:0] rounds;
   logic [TOPPLE_W-1:0] topples;
   logic [AREA_W-1:0]   area;
   cmd_type cmd;
   sts_type sts;

   assign go = req.valid && req.ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cons_ff <= 1'b0; area_en_ff <= 1'b1;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_CONSERVATIVE) cons_ff <= csr_write_data;
         if (csr_index == CSR_AREA) area_en_ff <= csr_write_data;
      end
   end

   bsdr_ctrl u_ctrl (
      .clock, .reset, .req_go(go), .req_ready(req.ready), .rsp_load(load),
      .rsp_busy(vld_ff && !rsp.ready), .cmd, .sts
   );

   bsdr_dp #(.LATTICE_COLS(LATTICE_COLS), .LATTICE_ROWS(LATTICE_ROWS)) u_dp (
      .clock, .reset, .req_go(go), .req_col(req.drive_col), .req_row(req.drive_row),
      .conservative(cons_ff), .cmd, .sts, .rounds, .topples, .area
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (load) vld_ff <= 1'b1;
      else if (rsp.ready) vld_ff <= 1'b0;
      if (load) begin
         rsp.avalanche_rounds <= rounds;
         rsp.avalanche_topplings <= topples;
         rsp.avalanche_area <= area_en_ff ? area : '0;
      end
   end
   assign rsp.valid = vld_ff;
endmodule
